/* src/fraction_add_reduce_assert.svh */
// Assertion macros for the fraction adder.
// Used by the front and back modules; no other dependencies.
`ifndef FRACTION_ADD_REDUCE_ASSERT_SVH
`define FRACTION_ADD_REDUCE_ASSERT_SVH
`ifndef SYNTH
`define FAR_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FAR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FAR_ASSERT_IMPL(label, clk, rst_n, a, c)
`define FAR_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* src/far_pkg.sv */
// Shared constants for the fraction adder.
// No dependencies.
`default_nettype none
package far_pkg;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int FIELD_WIDTH = 32;
endpackage
`default_nettype wire

/* src/fraction_add_reduce.sv */
// Fraction adder top level: front (products) and back (GCD, division).
// The GCD remainder steps and the final divisions all run through the shared
// bit-serial divider in the back; a zero sum skips the divider.
// The receiver cannot stall.
// One item at a time: busy stays high until the result transfer, so the next
// item can be accepted in the cycle after the result strobe. Reset is synchronous, active low.
`default_nettype none
module fraction_add_reduce #(
    parameter int VALUE_WIDTH = far_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_lhs_numerator,
    input  wire logic [31:0] i_lhs_denominator,
    input  wire logic [31:0] i_rhs_numerator,
    input  wire logic [31:0] i_rhs_denominator,
    output logic             o_strobe,
    output logic [31:0]      o_sum_numerator,
    output logic [31:0]      o_sum_denominator
);
    localparam int W = VALUE_WIDTH;
    logic f_busy, f_valid, b_ready, f_zero, r_inflight;
    logic [W-1:0] f_num, f_den, b_num, b_den;

    function automatic logic [W-1:0] ld(input logic [31:0] v);
        logic [95:0] e;
        e = {{64{v[31]}}, v};
        return e[W-1:0];
    endfunction

    function automatic logic [31:0] st(input logic [W-1:0] v);
        logic [95:0] e;
        e = {{(96-W){1'b0}}, v};
        return e[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= 1'b0;
        else if (start && !busy) r_inflight <= 1'b1;
        else if (o_strobe) r_inflight <= 1'b0;
    end
    assign busy = f_busy || r_inflight;

    far_front #(.W(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy), .o_busy(f_busy),
        .i_a(ld(i_lhs_numerator)), .i_b(ld(i_lhs_denominator)),
        .i_c(ld(i_rhs_numerator)), .i_d(ld(i_rhs_denominator)),
        .o_valid(f_valid), .i_ready(b_ready), .o_num(f_num), .o_den(f_den), .o_zero(f_zero)
    );

    far_back #(.W(W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_ready(b_ready),
        .i_num(f_num), .i_den(f_den), .i_zero(f_zero),
        .o_strobe(o_strobe), .o_num(b_num), .o_den(b_den)
    );

    assign o_sum_numerator = st(b_num);
    assign o_sum_denominator = st(b_den);
endmodule
`default_nettype wire

/* src/far_front.sv */
// Front part: accepts an item, forms the sum with a shared multiplier and
// classifies it. Depends on far_pkg and the assertion header.
`default_nettype none
`include "fraction_add_reduce_assert.svh"
module far_front #(
    parameter int W = far_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_c,
    input  wire logic [W-1:0] i_d,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_num,
    output logic [W-1:0]      o_den,
    output logic              o_zero
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_step;
    logic [W-1:0] r_a, r_b, r_c, r_d, r_num, r_den, r_prod;
    logic [W-1:0] mul_x, mul_y, num_fin, den_fin;
    logic [2*W-1:0] prod_full;

    always_comb begin
        case (r_step)
            2'd0: begin mul_x = r_a; mul_y = r_d; end
            2'd1: begin mul_x = r_c; mul_y = r_b; end
            default: begin mul_x = r_b; mul_y = r_d; end
        endcase
    end
    assign prod_full = mul_x * mul_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_step <= (r_step == 2'd3) ? 2'd0 : r_step + 2'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL: if (r_step == 2'd3) n_state = S_OUT;
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_a <= i_a; r_b <= i_b; r_c <= i_c; r_d <= i_d;
        end
        if (r_state == S_MUL) begin
            r_prod <= prod_full[W-1:0];
            case (r_step)
                2'd1: r_num <= r_prod + prod_full[W-1:0];
                2'd2: r_den <= prod_full[W-1:0];
                default: ;
            endcase
        end
    end

    assign num_fin = r_den[W-1] ? (~r_num + 1'b1) : r_num;
    assign den_fin = r_den[W-1] ? (~r_den + 1'b1) : r_den;
    assign o_busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_zero = (r_num == '0);
    assign o_num = num_fin;
    assign o_den = den_fin;

    `FAR_ASSERT_NEXT(a_start_leaves_idle, i_clk, i_rst_n, !o_busy && i_start, r_state == S_MUL)
    `FAR_ASSERT_IMPL(a_step_only_in_mul, i_clk, i_rst_n, r_state != S_MUL, r_step == 2'd0)
    `FAR_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_num))
endmodule
`default_nettype wire

/* src/far_back.sv */
// Back part: Euclidean GCD and final divisions through one shared
// restoring divider. Depends on far_pkg and the assertion header.
`default_nettype none
`include "fraction_add_reduce_assert.svh"
module far_back #(
    parameter int W = far_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    input  wire logic         i_zero,
    output logic              o_strobe,
    output logic [W-1:0]      o_num,
    output logic [W-1:0]      o_den
);
    localparam int CW = $clog2(W + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD = 3'd1;
    localparam logic [2:0] S_DN = 3'd2;
    localparam logic [2:0] S_DD = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0] r_state;
    logic [W-1:0] r_num, r_den, r_x, r_y, r_g;
    logic [W-1:0] r_q, r_rem, r_dvd, r_qn;
    logic [CW-1:0] r_cnt;
    logic r_div_go;
    logic [W:0] trial;
    logic [W-1:0] mag_num, mag_den, rem_sh;

    assign mag_num = r_num[W-1] ? (~r_num + 1'b1) : r_num;
    assign mag_den = r_den[W-1] ? (~r_den + 1'b1) : r_den;
    assign rem_sh = {r_rem[W-2:0], r_dvd[W-1]};
    assign trial = {r_rem, r_dvd[W-1]} - {1'b0, r_state == S_GCD ? r_y : r_g};
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div_go <= 1'b0;
            r_cnt <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_state == S_OUT) || (r_state == S_IDLE && i_valid && i_zero);
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_num <= i_num; r_den <= i_den;
                    if (i_zero) begin
                        o_num <= '0;
                        o_den <= {{(W-1){1'b0}}, 1'b1};
                    end else begin
                        r_x <= i_num[W-1] ? (~i_num + 1'b1) : i_num;
                        r_y <= i_den[W-1] ? (~i_den + 1'b1) : i_den;
                        r_state <= S_GCD;
                        r_div_go <= 1'b1;
                    end
                end
                S_GCD, S_DN, S_DD: begin
                    if (r_div_go) begin
                        if (r_state == S_GCD && r_y == '0) begin
                            r_g <= r_x;
                            r_state <= S_DN;
                        end else begin
                            r_dvd <= (r_state == S_GCD) ? r_x :
                                     (r_state == S_DN) ? mag_num : mag_den;
                            r_rem <= '0; r_q <= '0;
                            r_cnt <= CW'(W);
                            r_div_go <= 1'b0;
                        end
                    end else if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_dvd <= {r_dvd[W-2:0], 1'b0};
                        if (!trial[W]) begin
                            r_rem <= trial[W-1:0];
                            r_q <= {r_q[W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_q <= {r_q[W-2:0], 1'b0};
                        end
                    end else begin
                        case (r_state)
                            S_GCD: begin
                                r_x <= r_y; r_y <= r_rem;
                                r_div_go <= 1'b1;
                            end
                            S_DN: begin
                                r_qn <= r_num[W-1] ? (~r_q + 1'b1) : r_q;
                                r_state <= S_DD;
                                r_div_go <= 1'b1;
                            end
                            default: begin
                                o_num <= r_qn;
                                o_den <= r_den[W-1] ? (~r_q + 1'b1) : r_q;
                                r_div_go <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FAR_ASSERT_IMPL(a_gcd_nonzero, i_clk, i_rst_n, r_state == S_DN, r_g != '0)
    `FAR_ASSERT_NEXT(a_out_strobes, i_clk, i_rst_n, r_state == S_OUT, o_strobe)
    `FAR_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(W))
endmodule
`default_nettype wire
